FILE: hdl/password_policy_checker_macros.svh
// assertion macros for the password policy checker
`ifndef PASSWORD_POLICY_CHECKER_MACROS_SVH
`define PASSWORD_POLICY_CHECKER_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication, checked outside reset
`define PWPC_ASSERT_IMPLY(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("password policy checker: assertion failed");

// next-cycle implication, checked outside reset
`define PWPC_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("password policy checker: assertion failed");

`else

`define PWPC_ASSERT_IMPLY(label, clk, rst_n, cond, prop)
`define PWPC_ASSERT_NEXT(label, clk, rst_n, cond, prop)

`endif

`endif

FILE: hdl/pwpc_pkg.sv
// shared constants, register indexes and byte classification for the password checker
`default_nettype none

package pwpc_pkg;

    localparam int COUNT_WIDTH_DEF = 16;
    localparam int CFG_DATA_W      = 16;
    localparam int CFG_INDEX_W     = 3;
    localparam int LEN_W           = 16;
    localparam int CLASS_CNT_W     = 3;
    localparam int CLASS_W         = 4;

    // class mask bits
    localparam logic [CLASS_W-1:0] CLS_LOWER = 4'b0001;
    localparam logic [CLASS_W-1:0] CLS_UPPER = 4'b0010;
    localparam logic [CLASS_W-1:0] CLS_DIGIT = 4'b0100;
    localparam logic [CLASS_W-1:0] CLS_OTHER = 4'b1000;

    localparam logic [7:0] CHAR_DIGIT_FIRST = 8'h30;
    localparam logic [7:0] CHAR_DIGIT_LAST  = 8'h39;
    localparam logic [7:0] CHAR_UPPER_FIRST = 8'h41;
    localparam logic [7:0] CHAR_UPPER_LAST  = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_FIRST = 8'h61;
    localparam logic [7:0] CHAR_LOWER_LAST  = 8'h7A;
    localparam logic [7:0] SIGNED_BYTE_MAX  = 8'h7F;

    // register reset values
    localparam logic [LEN_W-1:0]       MIN_LENGTH_RST    = 16'd0;
    localparam logic [LEN_W-1:0]       MAX_LENGTH_RST    = 16'd255;
    localparam logic [CLASS_CNT_W-1:0] MIN_CLASSES_RST   = 3'd0;
    localparam logic [CLASS_W-1:0]     REQUIRED_RST      = 4'd0;
    localparam logic [CLASS_W-1:0]     FORBIDDEN_RST     = 4'd0;
    localparam logic [LEN_W-1:0]       MAX_REPEAT_RST    = 16'd65535;
    localparam logic [LEN_W-1:0]       MAX_ASCENDING_RST = 16'd65535;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_MIN_LENGTH        = 3'd0,
        REG_MAX_LENGTH        = 3'd1,
        REG_MIN_CLASSES       = 3'd2,
        REG_REQUIRED_CLASSES  = 3'd3,
        REG_FORBIDDEN_CLASSES = 3'd4,
        REG_MAX_REPEAT        = 3'd5,
        REG_MAX_ASCENDING     = 3'd6
    } cfg_reg_t;

    function automatic logic [CLASS_W-1:0] classify(input logic [7:0] b);
        logic [CLASS_W-1:0] cls;
        if (b >= CHAR_LOWER_FIRST && b <= CHAR_LOWER_LAST) begin
            cls = CLS_LOWER;
        end else if (b >= CHAR_UPPER_FIRST && b <= CHAR_UPPER_LAST) begin
            cls = CLS_UPPER;
        end else if (b >= CHAR_DIGIT_FIRST && b <= CHAR_DIGIT_LAST) begin
            cls = CLS_DIGIT;
        end else begin
            cls = CLS_OTHER;
        end
        return cls;
    endfunction

    function automatic logic [CLASS_CNT_W-1:0] popcount4(input logic [CLASS_W-1:0] m);
        return CLASS_CNT_W'(m[0]) + CLASS_CNT_W'(m[1]) + CLASS_CNT_W'(m[2])
             + CLASS_CNT_W'(m[3]);
    endfunction

endpackage

`default_nettype wire

FILE: hdl/password_policy_checker.sv
// password policy checker: byte-serial classification, run tracking and verdict
//
// The checker takes one password byte per transfer and returns one verdict
// (accepted) on the transfer that carries last_byte; other bytes produce no
// result. The per-password counters and flags update at the input transfer,
// and the verdict lands in an output register in the cycle after the final
// byte is taken, so one byte per clock is sustained while in_stall is low.
// in_stall is raised only while a verdict sits in the output register and
// out_stall holds it. Length and run counters are COUNT_WIDTH bits and
// saturate at their maximum. Configuration writes take effect at once and
// are meant to happen only between passwords; an index of 7 is ignored.
`default_nettype none

`include "password_policy_checker_macros.svh"

module password_policy_checker #(
    parameter int COUNT_WIDTH = pwpc_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_write,
    input  wire logic [pwpc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [pwpc_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [7:0]                     char_byte,
    input  wire logic                           last_byte,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic                                accepted
);
    import pwpc_pkg::*;

    localparam int CMP_W = (COUNT_WIDTH > LEN_W) ? COUNT_WIDTH : LEN_W;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
    localparam logic [COUNT_WIDTH-1:0] COUNT_ONE = COUNT_WIDTH'(1);

    // configuration registers
    logic [LEN_W-1:0]       min_length_reg;
    logic [LEN_W-1:0]       max_length_reg;
    logic [CLASS_CNT_W-1:0] min_classes_reg;
    logic [CLASS_W-1:0]     required_reg;
    logic [CLASS_W-1:0]     forbidden_reg;
    logic [LEN_W-1:0]       max_repeat_reg;
    logic [LEN_W-1:0]       max_ascending_reg;

    // per-password state
    logic [COUNT_WIDTH-1:0] length_count_reg, length_count_next;
    logic [CLASS_W-1:0]     classes_seen_reg, classes_seen_next;
    logic [7:0]             previous_byte_reg, previous_byte_next;
    logic [COUNT_WIDTH-1:0] repeat_run_reg, repeat_run_next;
    logic [COUNT_WIDTH-1:0] ascending_run_reg, ascending_run_next;
    logic                   repeat_violation_reg, repeat_violation_next;
    logic                   ascending_violation_reg, ascending_violation_next;
    logic                   at_start_reg, at_start_next;

    // output stage
    logic                   out_valid_reg, out_valid_next;
    logic                   accepted_reg, accepted_next;

    logic                   in_fire;
    logic                   out_fire;
    logic [COUNT_WIDTH-1:0] length_inc;
    logic [COUNT_WIDTH-1:0] repeat_upd;
    logic [COUNT_WIDTH-1:0] ascending_upd;
    logic                   is_repeat;
    logic                   is_ascending;
    logic                   rep_over;
    logic                   asc_over;
    logic                   verdict;

    assign in_stall  = out_valid_reg && out_stall;
    assign in_fire   = in_valid && !in_stall;
    assign out_fire  = out_valid_reg && !out_stall;
    assign out_valid = out_valid_reg;
    assign accepted  = accepted_reg;

    // configuration port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_length_reg    <= MIN_LENGTH_RST;
            max_length_reg    <= MAX_LENGTH_RST;
            min_classes_reg   <= MIN_CLASSES_RST;
            required_reg      <= REQUIRED_RST;
            forbidden_reg     <= FORBIDDEN_RST;
            max_repeat_reg    <= MAX_REPEAT_RST;
            max_ascending_reg <= MAX_ASCENDING_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_MIN_LENGTH:        min_length_reg    <= cfg_data[LEN_W-1:0];
                REG_MAX_LENGTH:        max_length_reg    <= cfg_data[LEN_W-1:0];
                REG_MIN_CLASSES:       min_classes_reg   <= cfg_data[CLASS_CNT_W-1:0];
                REG_REQUIRED_CLASSES:  required_reg      <= cfg_data[CLASS_W-1:0];
                REG_FORBIDDEN_CLASSES: forbidden_reg     <= cfg_data[CLASS_W-1:0];
                REG_MAX_REPEAT:        max_repeat_reg    <= cfg_data[LEN_W-1:0];
                REG_MAX_ASCENDING:     max_ascending_reg <= cfg_data[LEN_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        length_count_next        = length_count_reg;
        classes_seen_next        = classes_seen_reg;
        previous_byte_next       = previous_byte_reg;
        repeat_run_next          = repeat_run_reg;
        ascending_run_next       = ascending_run_reg;
        repeat_violation_next    = repeat_violation_reg;
        ascending_violation_next = ascending_violation_reg;
        at_start_next            = at_start_reg;
        out_valid_next           = out_fire ? 1'b0 : out_valid_reg;
        accepted_next            = accepted_reg;

        length_inc = (length_count_reg == COUNT_MAX) ? COUNT_MAX
                                                     : length_count_reg + COUNT_ONE;

        is_repeat = (char_byte == previous_byte_reg);
        // signed compare: 0x7f to 0x80 breaks the run, 0xff to 0x00 continues it
        is_ascending = (char_byte == previous_byte_reg + 8'd1)
                    && (previous_byte_reg != SIGNED_BYTE_MAX);

        repeat_upd = !is_repeat ? COUNT_ONE
                   : (repeat_run_reg == COUNT_MAX) ? COUNT_MAX
                   : repeat_run_reg + COUNT_ONE;
        ascending_upd = !is_ascending ? COUNT_ONE
                      : (ascending_run_reg == COUNT_MAX) ? COUNT_MAX
                      : ascending_run_reg + COUNT_ONE;

        rep_over = CMP_W'(repeat_upd) > CMP_W'(max_repeat_reg);
        asc_over = CMP_W'(ascending_upd) > CMP_W'(max_ascending_reg);

        length_count_next = length_inc;
        classes_seen_next = classes_seen_reg | classify(char_byte);
        // run limits only apply from the second byte on
        if (!at_start_reg)
        begin
            repeat_run_next          = repeat_upd;
            ascending_run_next       = ascending_upd;
            repeat_violation_next    = repeat_violation_reg || rep_over;
            ascending_violation_next = ascending_violation_reg || asc_over;
        end

        verdict = (CMP_W'(length_count_next) >= CMP_W'(min_length_reg))
               && (CMP_W'(length_count_next) <= CMP_W'(max_length_reg))
               && (popcount4(classes_seen_next) >= min_classes_reg)
               && ((classes_seen_next & required_reg) == required_reg)
               && ((classes_seen_next & forbidden_reg) == '0)
               && !repeat_violation_next
               && !ascending_violation_next;

        if (in_fire)
        begin
            if (last_byte)
            begin
                out_valid_next           = 1'b1;
                accepted_next            = verdict;
                length_count_next        = '0;
                classes_seen_next        = '0;
                previous_byte_next       = '0;
                repeat_run_next          = COUNT_ONE;
                ascending_run_next       = COUNT_ONE;
                repeat_violation_next    = 1'b0;
                ascending_violation_next = 1'b0;
                at_start_next            = 1'b1;
            end
            else
            begin
                previous_byte_next = char_byte;
                at_start_next      = 1'b0;
            end
        end
        else
        begin
            length_count_next        = length_count_reg;
            classes_seen_next        = classes_seen_reg;
            repeat_run_next          = repeat_run_reg;
            ascending_run_next       = ascending_run_reg;
            repeat_violation_next    = repeat_violation_reg;
            ascending_violation_next = ascending_violation_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_count_reg        <= '0;
            classes_seen_reg        <= '0;
            previous_byte_reg       <= '0;
            repeat_run_reg          <= COUNT_ONE;
            ascending_run_reg       <= COUNT_ONE;
            repeat_violation_reg    <= 1'b0;
            ascending_violation_reg <= 1'b0;
            at_start_reg            <= 1'b1;
            out_valid_reg           <= 1'b0;
        end
        else
        begin
            length_count_reg        <= length_count_next;
            classes_seen_reg        <= classes_seen_next;
            previous_byte_reg       <= previous_byte_next;
            repeat_run_reg          <= repeat_run_next;
            ascending_run_reg       <= ascending_run_next;
            repeat_violation_reg    <= repeat_violation_next;
            ascending_violation_reg <= ascending_violation_next;
            at_start_reg            <= at_start_next;
            out_valid_reg           <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        accepted_reg <= accepted_next;
    end

    // a final byte leaves a verdict and a cleared password state
    `PWPC_ASSERT_NEXT(a_last_clears, clk, rst_n, in_fire && last_byte, out_valid_reg && at_start_reg && length_count_reg == '0)
    // an inner byte never brings up a new verdict once the old one is gone
    `PWPC_ASSERT_NEXT(a_inner_no_result, clk, rst_n, in_fire && !last_byte && out_fire, !out_valid_reg)
    // past the first byte the length counter is never zero
    `PWPC_ASSERT_IMPLY(a_len_nonzero, clk, rst_n, !at_start_reg, length_count_reg != '0)
    // at the start of a password the run trackers hold their idle values
    `PWPC_ASSERT_IMPLY(a_start_idle, clk, rst_n, at_start_reg, repeat_run_reg == COUNT_ONE && ascending_run_reg == COUNT_ONE && !repeat_violation_reg && !ascending_violation_reg)

endmodule

`default_nettype wire

FILE: dv/password_verdict_check.sv
`timescale 1ns / 1ps
// verdict prediction and comparison for the password policy checker testbench
module password_verdict_check (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [pwpc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [pwpc_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             in_valid,
    input  logic                             in_stall,
    input  logic [7:0]                       char_byte,
    input  logic                             last_byte,
    input  logic                             out_valid,
    input  logic                             out_stall,
    input  logic                             accepted,
    output int                               pending,
    output int                               fail_count
);
    import pwpc_pkg::*;

    localparam int unsigned COUNT_MAX = (1 << COUNT_WIDTH_DEF) - 1;

    // policy as last written
    logic [LEN_W-1:0]       min_len_lim;
    logic [LEN_W-1:0]       max_len_lim;
    logic [LEN_W-1:0]       same_lim;
    logic [LEN_W-1:0]       rise_lim;
    logic [CLASS_CNT_W-1:0] class_count_lim;
    logic [CLASS_W-1:0]     need_mask;
    logic [CLASS_W-1:0]     deny_mask;

    // progress through the current password
    int unsigned        pw_len;
    int unsigned        same_run;
    int unsigned        rise_run;
    logic [CLASS_W-1:0] seen;
    logic [7:0]         prev_byte;
    logic               same_bad;
    logic               rise_bad;
    logic               fresh;

    logic verdict_q[$];

    function automatic logic [CLASS_W-1:0] byte_class(input logic [7:0] b);
        if (b inside {[CHAR_LOWER_FIRST:CHAR_LOWER_LAST]})
            return CLS_LOWER;
        if (b inside {[CHAR_UPPER_FIRST:CHAR_UPPER_LAST]})
            return CLS_UPPER;
        if (b inside {[CHAR_DIGIT_FIRST:CHAR_DIGIT_LAST]})
            return CLS_DIGIT;
        return CLS_OTHER;
    endfunction

    function automatic int unsigned bump(input int unsigned v);
        return (v >= COUNT_MAX) ? COUNT_MAX : v + 1;
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] verdict mismatch: %s", $time, what);
        fail_count++;
    endtask

    task automatic clear_progress();
        pw_len    = 0;
        same_run  = 1;
        rise_run  = 1;
        seen      = '0;
        prev_byte = 8'h00;
        same_bad  = 1'b0;
        rise_bad  = 1'b0;
        fresh     = 1'b1;
    endtask

    task automatic apply_write(input logic [CFG_INDEX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_MIN_LENGTH:        min_len_lim     = data[LEN_W-1:0];
            REG_MAX_LENGTH:        max_len_lim     = data[LEN_W-1:0];
            REG_MIN_CLASSES:       class_count_lim = data[CLASS_CNT_W-1:0];
            REG_REQUIRED_CLASSES:  need_mask       = data[CLASS_W-1:0];
            REG_FORBIDDEN_CLASSES: deny_mask       = data[CLASS_W-1:0];
            REG_MAX_REPEAT:        same_lim        = data[LEN_W-1:0];
            REG_MAX_ASCENDING:     rise_lim        = data[LEN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic absorb_byte(input logic [7:0] b, input logic last);
        int   cur_s;
        int   prev_s;
        logic ok;
        cur_s  = $signed(b);
        prev_s = $signed(prev_byte);
        pw_len = bump(pw_len);
        seen   = seen | byte_class(b);
        // run limits only apply once there is a previous byte
        if (!fresh)
        begin
            same_run = (b == prev_byte) ? bump(same_run) : 1;
            rise_run = (cur_s == prev_s + 1) ? bump(rise_run) : 1;
            if (same_run > same_lim)
                same_bad = 1'b1;
            if (rise_run > rise_lim)
                rise_bad = 1'b1;
        end
        prev_byte = b;
        fresh     = 1'b0;
        if (last)
        begin
            ok = pw_len >= min_len_lim && pw_len <= max_len_lim
                 && $countones(seen) >= class_count_lim
                 && (seen & need_mask) == need_mask
                 && (seen & deny_mask) == '0
                 && !same_bad && !rise_bad;
            verdict_q = {verdict_q, ok};
            clear_progress();
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        logic want;
        if (!rst_n)
        begin
            min_len_lim     = MIN_LENGTH_RST;
            max_len_lim     = MAX_LENGTH_RST;
            class_count_lim = MIN_CLASSES_RST;
            need_mask       = REQUIRED_RST;
            deny_mask       = FORBIDDEN_RST;
            same_lim        = MAX_REPEAT_RST;
            rise_lim        = MAX_ASCENDING_RST;
            clear_progress();
            verdict_q.delete();
            fail_count = 0;
            pending <= 0;
        end
        else
        begin
            // results leave a register, so the oldest expectation is matched first
            if (out_valid && !out_stall)
            begin
                if (verdict_q.size() == 0)
                    report_mismatch($sformatf("unexpected verdict %b", accepted));
                else
                begin
                    want = verdict_q.pop_front();
                    if (accepted !== want)
                        report_mismatch($sformatf("accepted %b, predicted %b",
                                                  accepted, want));
                end
            end
            if (cfg_write)
                apply_write(cfg_index, cfg_data);
            if (in_valid && !in_stall)
                absorb_byte(char_byte, last_byte);
            pending <= verdict_q.size();
        end
    end

endmodule

FILE: dv/password_policy_checker_tb.sv
`timescale 1ns / 1ps
// testbench top for the password policy checker: clock, reset, stimulus and verdict
module password_policy_checker_tb;
    import pwpc_pkg::*;

    localparam int RANDOM_ITEMS = 1400;
    localparam int HOLD_CYCLES  = 300;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;

    typedef enum int {STYLE_NOISE, STYLE_REPEAT, STYLE_RISING, STYLE_MIXED} pw_style_t;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   in_valid  = 1'b0;
    logic                   in_stall;
    logic [7:0]             char_byte = 8'h00;
    logic                   last_byte = 1'b0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic                   accepted;
    int                     pending;
    int                     fail_count;

    bit         idle_on         = 1'b1;
    int         holds_requested = 0;
    int         holds_done      = 0;
    int         items_sent      = 0;
    logic [7:0] pw_bytes[$];

    password_policy_checker u_dut (.*);

    password_verdict_check u_verdict_check (.*);

    always #1 clk = ~clk;

    initial
    begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // receiver: random stalls, plus long hold-offs on request
    initial
    begin
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (holds_requested != holds_done)
            begin
                holds_done++;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            out_stall <= idle_on && ($urandom_range(99) < 6);
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        while (idle_on && $urandom_range(99) < 6)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        char_byte <= b;
        last_byte <= last;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        items_sent++;
    endtask

    task automatic send_pw_bytes();
        foreach (pw_bytes[i])
            send_byte(pw_bytes[i], i == pw_bytes.size() - 1);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    // stop sending and wait for every verdict to come out
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [15:0] pick_limit(input int unsigned small_hi);
        case ($urandom_range(5))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return 16'($urandom);
            default: return 16'($urandom_range(small_hi));
        endcase
    endfunction

    function automatic logic [7:0] class_byte(input int unsigned k);
        case (k)
            0: return 8'($urandom_range(CHAR_LOWER_FIRST, CHAR_LOWER_LAST));
            1: return 8'($urandom_range(CHAR_UPPER_FIRST, CHAR_UPPER_LAST));
            2: return 8'($urandom_range(CHAR_DIGIT_FIRST, CHAR_DIGIT_LAST));
            default:
                if ($urandom_range(1) == 0)
                    return 8'($urandom_range(8'h7B, 8'hFF));
                else
                    return 8'($urandom_range(0, 8'h2F));
        endcase
    endfunction

    task automatic random_policy();
        int unsigned n_cls;
        logic [CLASS_W-1:0] mask;
        write_reg(REG_MIN_LENGTH, pick_limit(8));
        write_reg(REG_MAX_LENGTH, ($urandom_range(3) == 0) ? pick_limit(40)
                                  : 16'($urandom_range(4, 40)));
        // unused upper data bits are random so the block must mask them
        n_cls = ($urandom_range(7) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 3);
        write_reg(REG_MIN_CLASSES, {13'($urandom), 3'(n_cls)});
        mask = ($urandom_range(2) == 0) ? 4'($urandom) : 4'd0;
        write_reg(REG_REQUIRED_CLASSES, {12'($urandom), mask});
        mask = ($urandom_range(3) == 0) ? 4'($urandom) : 4'd0;
        write_reg(REG_FORBIDDEN_CLASSES, {12'($urandom), mask});
        write_reg(REG_MAX_REPEAT, pick_limit(4));
        write_reg(REG_MAX_ASCENDING, pick_limit(4));
        if ($urandom_range(3) == 0)
            write_reg(REG_UNUSED, 16'($urandom));
    endtask

    task automatic make_password(input int len, input pw_style_t style);
        logic [7:0] b;
        pw_bytes.delete();
        b = 8'($urandom);
        for (int i = 0; i < len; i++)
        begin
            case (style)
                STYLE_REPEAT:
                    if ($urandom_range(4) == 0)
                        b = 8'($urandom);
                STYLE_RISING:
                    if ($urandom_range(6) == 0)
                        b = 8'($urandom);
                    else
                        b = b + 8'd1;
                STYLE_MIXED:
                    b = class_byte($urandom_range(3));
                default:
                    b = 8'($urandom);
            endcase
            pw_bytes = {pw_bytes, b};
        end
    endtask

    initial
    begin
        int phase;
        int phase_end;
        int random_start;
        int len;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset policy, single bytes at both ends of the byte range
        pw_bytes = '{8'h00};
        send_pw_bytes();
        pw_bytes = '{8'hFF};
        send_pw_bytes();

        // class range edges with every class required
        drain();
        write_reg(REG_REQUIRED_CLASSES, 16'(CLS_LOWER | CLS_UPPER | CLS_DIGIT | CLS_OTHER));
        write_reg(REG_MIN_CLASSES, 16'd4);
        pw_bytes = '{8'h60, 8'h7A, 8'h41, 8'h5B, 8'h39, 8'h3A};
        send_pw_bytes();
        pw_bytes = '{8'h61, 8'h5A, 8'h30, 8'h7B};
        send_pw_bytes();

        // signed wrap: 7f->80 breaks a rising run, ff->00 extends it
        drain();
        write_reg(REG_REQUIRED_CLASSES, 16'd0);
        write_reg(REG_MIN_CLASSES, 16'd0);
        write_reg(REG_MAX_ASCENDING, 16'd1);
        pw_bytes = '{8'h7F, 8'h80};
        send_pw_bytes();
        pw_bytes = '{8'hFF, 8'h00};
        send_pw_bytes();

        // zero repeat limit: one byte passes, two never do
        drain();
        write_reg(REG_MAX_ASCENDING, 16'hFFFF);
        write_reg(REG_MAX_REPEAT, 16'd0);
        pw_bytes = '{8'h55};
        send_pw_bytes();
        pw_bytes = '{8'h55, 8'h55};
        send_pw_bytes();

        // class count above four can never be met
        drain();
        write_reg(REG_MAX_REPEAT, 16'hFFFF);
        write_reg(REG_MIN_CLASSES, 16'd5);
        pw_bytes = '{8'h41};
        send_pw_bytes();

        drain();
        write_reg(REG_MIN_CLASSES, 16'd0);
        write_reg(REG_FORBIDDEN_CLASSES, 16'(CLS_DIGIT));
        pw_bytes = '{8'h35};
        send_pw_bytes();

        drain();
        write_reg(REG_FORBIDDEN_CLASSES, 16'd0);
        write_reg(REG_MIN_LENGTH, 16'd2);
        write_reg(REG_MAX_LENGTH, 16'd2);
        write_reg(REG_UNUSED, 16'hFFFF);
        pw_bytes = '{8'h01, 8'h02};
        send_pw_bytes();

        random_start = items_sent;
        phase = 0;
        while (items_sent - random_start < RANDOM_ITEMS)
        begin
            drain();
            random_policy();
            idle_on = !(phase >= 4 && phase <= 6);
            // long receiver hold-off while passwords keep coming
            if (phase == 8)
                holds_requested++;
            phase_end = items_sent + $urandom_range(30, 120);
            while (items_sent < phase_end)
            begin
                len = ($urandom_range(9) == 0) ? $urandom_range(11, 40)
                                               : $urandom_range(1, 10);
                make_password(len, pw_style_t'($urandom_range(3)));
                send_pw_bytes();
            end
            phase++;
        end

        drain();
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
